### sv/uets_pkg.sv
package uets_pkg;

  localparam int ENDPOINTS  = 8;
  localparam int EP0_PACKET = 64;

  localparam int ACT_W  = 2;
  localparam int EP_W   = 3;
  localparam int PS_W   = 10;
  localparam int XT_W   = 2;
  localparam int SLOT_W = 3;
  localparam int LEN_W  = 16;
  localparam int RC_W   = 10;
  localparam int OC_W   = 3;
  localparam int MP_W   = 11;

  localparam int TBL_DEPTH = 16;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    A_OPEN     = 2'd0,
    A_START    = 2'd1,
    A_IN_SENT  = 2'd2,
    A_OUT_RECV = 2'd3
  } action_t;

  typedef enum logic [XT_W-1:0] {
    XT_CONTROL   = 2'd0,
    XT_ISO       = 2'd1,
    XT_BULK      = 2'd2,
    XT_INTERRUPT = 2'd3
  } xfer_type_t;

  typedef enum logic [OC_W-1:0] {
    OC_OPENED   = 3'd0,
    OC_REJECTED = 3'd1,
    OC_SEND     = 3'd2,
    OC_ARM      = 3'd3,
    OC_REARM    = 3'd4,
    OC_DONE     = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    K_OPEN      = 3'd0,
    K_REJECT    = 3'd1,
    K_START_IN  = 3'd2,
    K_START_OUT = 3'd3,
    K_IN_SENT   = 3'd4,
    K_OUT_RECV  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [EP_W-1:0]    endpoint;
    logic               direction;
    logic [PS_W-1:0]    max_pkt_size;
    logic [SLOT_W-1:0]  hardware_slot;
    logic [LEN_W-1:0]   total_length;
    logic [RC_W-1:0]    received_count;
  } item_t;

  function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                               input logic [MP_W-1:0] b);
    logic [LEN_W-1:0] bx;
    bx = LEN_W'(b);
    return (a < bx) ? a : bx;
  endfunction

endpackage

### sv/uets_in_if.sv
interface uets_in_if;
  import uets_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [EP_W-1:0]     endpoint;
  logic                direction;
  logic [PS_W-1:0]     max_pkt_size;
  logic [XT_W-1:0]     xfer_type;
  logic [SLOT_W-1:0]   hardware_slot;
  logic [LEN_W-1:0]    total_length;
  logic [RC_W-1:0]     received_count;

  modport source (output valid, action, endpoint, direction, max_pkt_size, xfer_type,
                  hardware_slot, total_length, received_count, input ready);
  modport sink (input valid, action, endpoint, direction, max_pkt_size, xfer_type,
                hardware_slot, total_length, received_count, output ready);
endinterface

### sv/uets_out_if.sv
interface uets_out_if;
  import uets_pkg::*;

  logic                valid;
  logic                ready;
  logic [OC_W-1:0]     outcome;
  logic [EP_W-1:0]     out_endpoint;
  logic                out_direction;
  logic [SLOT_W-1:0]   slot;
  logic [LEN_W-1:0]    length;
  logic [PS_W-1:0]     restore_size;

  modport source (output valid, outcome, out_endpoint, out_direction, slot, length,
                  restore_size, input ready);
  modport sink (input valid, outcome, out_endpoint, out_direction, slot, length,
                restore_size, output ready);
endinterface

### sv/usb_endpoint_transfer_segmenter.sv
// An accepted item is queued; when popped, its result is registered and then offered.
// Throughput: one item per cycle unless out_ch stalls, bound by one table read-modify-write.
// A four-entry queue separates intake from execution, so intake continues while a result waits.
// Reset clears the queue, the result valid flag and the endpoint table; endpoint zero
// returns to its default packet size in both directions.
module usb_endpoint_transfer_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  uets_in_if.sink     in_ch,
  uets_out_if.source  out_ch
);
  import uets_pkg::*;

  logic   push;
  item_t  push_item;
  logic   q_full;
  logic   q_nonempty;
  item_t  q_head;
  logic   pop;

  uets_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  uets_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  uets_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### sv/uets_front.sv
module uets_front (
  uets_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output uets_pkg::item_t  push_item
);
  import uets_pkg::*;

  logic   ep_ok;
  logic   keep;
  kind_t  kind;
  logic   dir;

  assign ep_ok = ({2'b00, in_ch.endpoint} < 5'(ENDPOINTS));

  always_comb begin
    kind = K_REJECT;
    dir  = in_ch.direction;
    keep = 1'b0;
    case (action_t'(in_ch.action))
      A_OPEN: begin
        keep = 1'b1;
        if (!ep_ok || (xfer_type_t'(in_ch.xfer_type) inside {XT_CONTROL, XT_ISO})) begin
          kind = K_REJECT;
        end else begin
          kind = K_OPEN;
        end
      end
      A_START: begin
        keep = ep_ok;
        kind = in_ch.direction ? K_START_IN : K_START_OUT;
      end
      A_IN_SENT: begin
        keep = ep_ok;
        kind = K_IN_SENT;
        dir  = 1'b1;
      end
      A_OUT_RECV: begin
        keep = ep_ok;
        kind = K_OUT_RECV;
        dir  = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Non-open items for an absent endpoint are taken and discarded here.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && keep;

  always_comb begin
    push_item.kind           = kind;
    push_item.endpoint       = in_ch.endpoint;
    push_item.direction      = dir;
    push_item.max_pkt_size   = in_ch.max_pkt_size;
    push_item.hardware_slot  = in_ch.hardware_slot;
    push_item.total_length   = in_ch.total_length;
    push_item.received_count = in_ch.received_count;
  end

endmodule

### sv/uets_queue.sv
module uets_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uets_pkg::item_t  push_item,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output uets_pkg::item_t  head
);
  import uets_pkg::*;

  item_t           mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  count_r, count_nxt;

  assign full     = (count_r == QCW'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
  assign count_nxt  = count_r + QCW'(push) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

### sv/uets_back.sv
module uets_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  uets_pkg::item_t  q_head,
  output logic             pop,
  uets_out_if.source       out_ch
);
  import uets_pkg::*;

  logic [LEN_W-1:0]   tl_r [TBL_DEPTH];
  logic [LEN_W-1:0]   mv_r [TBL_DEPTH];
  logic [MP_W-1:0]    mp_r [TBL_DEPTH];
  logic [SLOT_W-1:0]  sl_r [TBL_DEPTH];

  logic [TBL_AW-1:0]  ix;
  logic [LEN_W-1:0]   tl_cur, mv_cur;
  logic [MP_W-1:0]    mp_cur;
  logic [SLOT_W-1:0]  sl_cur;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   in_len;
  logic [LEN_W:0]     sum;
  logic [LEN_W-1:0]   nm;

  logic               wr_tl, wr_mv, wr_cfg;
  logic [LEN_W-1:0]   tl_nxt, mv_nxt;

  logic               out_valid_r;
  outcome_t           oc_r, oc_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [PS_W-1:0]    rs_r, rs_nxt;
  logic [EP_W-1:0]    ep_r;
  logic               dir_r;

  assign ix     = {q_head.endpoint, q_head.direction};
  assign tl_cur = tl_r[ix];
  assign mv_cur = mv_r[ix];
  assign mp_cur = mp_r[ix];
  assign sl_cur = sl_r[ix];

  assign rem    = (tl_cur > mv_cur) ? tl_cur - mv_cur : '0;
  assign in_len = min_len(rem, mp_cur);
  assign sum    = {1'b0, mv_cur} + (LEN_W + 1)'(q_head.received_count);
  assign nm     = sum[LEN_W] ? '1 : sum[LEN_W-1:0];

  assign pop = q_nonempty && (!out_valid_r || out_ch.ready);

  always_comb begin
    wr_tl    = 1'b0;
    wr_mv    = 1'b0;
    wr_cfg   = 1'b0;
    tl_nxt   = tl_cur;
    mv_nxt   = mv_cur;
    oc_nxt   = OC_REJECTED;
    slot_nxt = sl_cur;
    len_nxt  = '0;
    rs_nxt   = '0;
    case (q_head.kind)
      K_OPEN: begin
        wr_cfg   = 1'b1;
        oc_nxt   = OC_OPENED;
        slot_nxt = q_head.hardware_slot;
      end
      K_REJECT: begin
        oc_nxt   = OC_REJECTED;
        slot_nxt = '0;
      end
      K_START_IN: begin
        wr_tl   = 1'b1;
        wr_mv   = 1'b1;
        tl_nxt  = q_head.total_length;
        len_nxt = min_len(q_head.total_length, mp_cur);
        mv_nxt  = len_nxt;
        oc_nxt  = OC_SEND;
      end
      K_START_OUT: begin
        wr_tl   = 1'b1;
        wr_mv   = 1'b1;
        tl_nxt  = q_head.total_length;
        mv_nxt  = '0;
        len_nxt = min_len(q_head.total_length, mp_cur);
        oc_nxt  = OC_ARM;
      end
      K_IN_SENT: begin
        if (tl_cur != mv_cur) begin
          wr_mv   = 1'b1;
          mv_nxt  = mv_cur + in_len;
          len_nxt = in_len;
          oc_nxt  = OC_SEND;
        end else begin
          len_nxt = mv_cur;
          oc_nxt  = OC_DONE;
        end
      end
      K_OUT_RECV: begin
        wr_mv = 1'b1;
        if ((MP_W'(q_head.received_count) < mp_cur) || (nm >= tl_cur)) begin
          wr_tl   = 1'b1;
          tl_nxt  = '0;
          mv_nxt  = '0;
          len_nxt = nm;
          rs_nxt  = mp_cur[PS_W-1:0];
          oc_nxt  = OC_DONE;
        end else begin
          mv_nxt  = nm;
          len_nxt = min_len(tl_cur, mp_cur);
          oc_nxt  = OC_REARM;
        end
      end
      default: begin
        oc_nxt = OC_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        tl_r[i] <= '0;
        mv_r[i] <= '0;
        sl_r[i] <= '0;
        mp_r[i] <= (i < 2) ? MP_W'(EP0_PACKET) : '0;
      end
    end else if (pop) begin
      if (wr_tl) begin
        tl_r[ix] <= tl_nxt;
      end
      if (wr_mv) begin
        mv_r[ix] <= mv_nxt;
      end
      if (wr_cfg) begin
        mp_r[ix] <= MP_W'(q_head.max_pkt_size);
        sl_r[ix] <= q_head.hardware_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      oc_r   <= oc_nxt;
      slot_r <= slot_nxt;
      len_r  <= len_nxt;
      rs_r   <= rs_nxt;
      ep_r   <= q_head.endpoint;
      dir_r  <= q_head.direction;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.outcome       = oc_r;
  assign out_ch.out_endpoint  = ep_r;
  assign out_ch.out_direction = dir_r;
  assign out_ch.slot          = slot_r;
  assign out_ch.length        = len_r;
  assign out_ch.restore_size  = rs_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && out_valid_r && !out_ch.ready))
    else $error("held result overwritten");

  a_in_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_nonempty && q_head.direction) |-> (mv_cur <= tl_cur))
    else $error("IN moved count exceeds transfer length");

endmodule

### test/tb_usb_endpoint_transfer_segmenter.sv
module tb_usb_endpoint_transfer_segmenter;
  timeunit 1ns;
  timeprecision 1ps;

  import uets_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 34;

  typedef struct packed {
    action_t           action;
    logic [EP_W-1:0]   endpoint;
    logic              direction;
    logic [PS_W-1:0]   max_pkt_size;
    xfer_type_t        xfer_type;
    logic [SLOT_W-1:0] hardware_slot;
    logic [LEN_W-1:0]  total_length;
    logic [RC_W-1:0]   received_count;
  } ep_request_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [EP_W-1:0]   endpoint;
    logic              direction;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [PS_W-1:0]   restore_size;
  } ep_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  uets_in_if  in_ch ();
  uets_out_if out_ch ();

  usb_endpoint_transfer_segmenter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #4 clk = ~clk;

  logic [LEN_W-1:0]  xfer_len    [TBL_DEPTH];
  logic [LEN_W-1:0]  moved_bytes [TBL_DEPTH];
  logic [MP_W-1:0]   max_pkt     [TBL_DEPTH];
  logic [SLOT_W-1:0] slot_map    [TBL_DEPTH];

  ep_request_t pending_requests[$];
  ep_outcome_t expected_outcomes[$];
  ep_request_t current_req;

  int error_count    = 0;
  int cycle_count    = 0;
  int accepted_count = 0;
  int random_total   = 0;
  bit calm;

  assign calm = (accepted_count >= 300) && (accepted_count < 420);

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [LEN_W-1:0] capped(input logic [LEN_W-1:0] a,
                                              input logic [MP_W-1:0] b);
    if ({5'b0, b} < a) return {5'b0, b};
    return a;
  endfunction

  function automatic logic [LEN_W-1:0] next_in_len(input logic [TBL_AW-1:0] ix);
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] len;
    rem = (xfer_len[ix] > moved_bytes[ix]) ? xfer_len[ix] - moved_bytes[ix] : '0;
    len = capped(rem, max_pkt[ix]);
    moved_bytes[ix] = moved_bytes[ix] + len;
    return len;
  endfunction

  function automatic bit segment_step(input ep_request_t it, output ep_outcome_t r);
    logic [TBL_AW-1:0] ix;
    logic [LEN_W:0]    sum;
    r = '0;
    r.endpoint  = it.endpoint;
    r.direction = it.direction;
    ix = {it.endpoint, it.direction};
    if (it.action == A_OPEN) begin
      if (int'(it.endpoint) >= ENDPOINTS || it.xfer_type == XT_CONTROL ||
          it.xfer_type == XT_ISO) begin
        r.outcome = OC_REJECTED;
      end else begin
        max_pkt[ix]  = MP_W'(it.max_pkt_size);
        slot_map[ix] = it.hardware_slot;
        r.outcome    = OC_OPENED;
        r.slot       = it.hardware_slot;
      end
      return 1'b1;
    end
    if (int'(it.endpoint) >= ENDPOINTS) return 1'b0;
    case (it.action)
      A_START: begin
        xfer_len[ix]    = it.total_length;
        moved_bytes[ix] = '0;
        r.slot = slot_map[ix];
        if (it.direction) begin
          r.outcome = OC_SEND;
          r.length  = next_in_len(ix);
        end else begin
          r.outcome = OC_ARM;
          r.length  = capped(it.total_length, max_pkt[ix]);
        end
      end
      A_IN_SENT: begin
        ix = {it.endpoint, 1'b1};
        r.direction = 1'b1;
        r.slot = slot_map[ix];
        if (xfer_len[ix] != moved_bytes[ix]) begin
          r.outcome = OC_SEND;
          r.length  = next_in_len(ix);
        end else begin
          r.outcome = OC_DONE;
          r.length  = moved_bytes[ix];
        end
      end
      default: begin
        ix = {it.endpoint, 1'b0};
        r.direction = 1'b0;
        r.slot = slot_map[ix];
        sum = {1'b0, moved_bytes[ix]} + it.received_count;
        if (sum > 17'd65535) sum = 17'd65535;
        moved_bytes[ix] = sum[LEN_W-1:0];
        if ({1'b0, it.received_count} < max_pkt[ix] || sum[LEN_W-1:0] >= xfer_len[ix]) begin
          r.outcome       = OC_DONE;
          r.length        = sum[LEN_W-1:0];
          r.restore_size  = max_pkt[ix][PS_W-1:0];
          xfer_len[ix]    = '0;
          moved_bytes[ix] = '0;
        end else begin
          r.outcome = OC_REARM;
          r.length  = capped(xfer_len[ix], max_pkt[ix]);
        end
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    ep_outcome_t res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (segment_step(current_req, res)) expected_outcomes.push_back(res);
        accepted_count++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        current_req = pending_requests.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.action         <= current_req.action;
        in_ch.endpoint       <= current_req.endpoint;
        in_ch.direction      <= current_req.direction;
        in_ch.max_pkt_size   <= current_req.max_pkt_size;
        in_ch.xfer_type      <= current_req.xfer_type;
        in_ch.hardware_slot  <= current_req.hardware_slot;
        in_ch.total_length   <= current_req.total_length;
        in_ch.received_count <= current_req.received_count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ep_outcome_t got;
    ep_outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.outcome      = outcome_t'(out_ch.outcome);
      got.endpoint     = out_ch.out_endpoint;
      got.direction    = out_ch.out_direction;
      got.slot         = out_ch.slot;
      got.length       = out_ch.length;
      got.restore_size = out_ch.restore_size;
      if (expected_outcomes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer: outcome %0d ep %0d dir %0d slot %0d len %0d rs %0d",
                 $time, got.outcome, got.endpoint, got.direction, got.slot, got.length,
                 got.restore_size);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.outcome != want.outcome || got.endpoint != want.endpoint ||
            got.direction != want.direction || got.slot != want.slot ||
            got.length != want.length || got.restore_size != want.restore_size) begin
          error_count++;
          $display("%0t: mismatch: expected outcome %0d ep %0d dir %0d slot %0d len %0d rs %0d",
                   $time, want.outcome, want.endpoint, want.direction, want.slot,
                   want.length, want.restore_size);
          $display("%0t:           actual outcome %0d ep %0d dir %0d slot %0d len %0d rs %0d",
                   $time, got.outcome, got.endpoint, got.direction, got.slot, got.length,
                   got.restore_size);
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic ep_request_t req(input action_t a, input int ep, input int dir,
                                      input int ps, input xfer_type_t xt, input int sl,
                                      input int tot, input int rc);
    ep_request_t r;
    r.action         = a;
    r.endpoint       = EP_W'(ep);
    r.direction      = dir[0];
    r.max_pkt_size   = PS_W'(ps);
    r.xfer_type      = xt;
    r.hardware_slot  = SLOT_W'(sl);
    r.total_length   = LEN_W'(tot);
    r.received_count = RC_W'(rc);
    return r;
  endfunction

  function automatic ep_request_t rand_req();
    return req(action_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 1),
               $urandom_range(0, 1023), xfer_type_t'($urandom_range(0, 3)),
               $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 1023));
  endfunction

  task automatic queue_req(input ep_request_t r);
    pending_requests.push_back(r);
    random_total++;
    if ($urandom_range(0, 15) == 0) begin
      pending_requests.push_back(rand_req());
      random_total++;
    end
  endtask

  task automatic add_sequence(input bit long_run, input bit long_dir);
    ep_request_t r;
    int unsigned ep, dir, mp, total, sent, got, rem, k;
    bit          seq_done;
    ep  = $urandom_range(0, 7);
    dir = long_run ? long_dir : $urandom_range(0, 1);
    if (long_run) begin
      mp    = 1023;
      total = $urandom_range(60000, 65535);
    end else begin
      case ($urandom_range(0, 3))
        0:       mp = $urandom_range(8, 64);
        1:       mp = $urandom_range(1, 1023);
        2:       mp = 1023;
        default: mp = $urandom_range(1, 16);
      endcase
      total = mp * $urandom_range(0, 5) + $urandom_range(0, mp);
      if ($urandom_range(0, 9) == 0) total = 0;
    end
    r = rand_req();
    r.action       = A_OPEN;
    r.endpoint     = EP_W'(ep);
    r.direction    = dir[0];
    r.max_pkt_size = PS_W'(mp);
    r.xfer_type    = $urandom_range(0, 1) ? XT_BULK : XT_INTERRUPT;
    queue_req(r);
    r = rand_req();
    r.action       = A_START;
    r.endpoint     = EP_W'(ep);
    r.direction    = dir[0];
    r.total_length = LEN_W'(total);
    queue_req(r);
    seq_done = 1'b0;
    if (dir) begin
      sent = (mp < total) ? mp : total;
      k = 1;
      while (sent < total) begin
        sent += (mp < total - sent) ? mp : total - sent;
        k++;
      end
      while (k > 0 && !seq_done) begin
        r = rand_req();
        r.action   = A_IN_SENT;
        r.endpoint = EP_W'(ep);
        queue_req(r);
        k--;
        if (!long_run && $urandom_range(0, 19) == 0) seq_done = 1'b1;
      end
    end else begin
      got = 0;
      while (!seq_done) begin
        rem = total - got;
        r = rand_req();
        r.action   = A_OUT_RECV;
        r.endpoint = EP_W'(ep);
        if (rem >= mp) begin
          r.received_count = RC_W'(mp);
          got += mp;
          seq_done = (got >= total);
        end else begin
          r.received_count = $urandom_range(0, 1) ? RC_W'(mp) : RC_W'($urandom_range(0, rem));
          seq_done = 1'b1;
        end
        queue_req(r);
        if (!long_run && $urandom_range(0, 19) == 0) seq_done = 1'b1;
      end
    end
  endtask

  task automatic fill_random(input int target, input bit long_dir);
    add_sequence(1'b1, long_dir);
    while (random_total < target) begin
      if ($urandom_range(0, 99) < 80) add_sequence(1'b0, 1'b0);
      else queue_req(rand_req());
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_ch.valid || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.action         = '0;
    in_ch.endpoint       = '0;
    in_ch.direction      = 1'b0;
    in_ch.max_pkt_size   = '0;
    in_ch.xfer_type      = '0;
    in_ch.hardware_slot  = '0;
    in_ch.total_length   = '0;
    in_ch.received_count = '0;
    out_ch.ready         = 1'b0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      xfer_len[i]    = '0;
      moved_bytes[i] = '0;
      max_pkt[i]     = '0;
      slot_map[i]    = '0;
    end
    max_pkt[0] = MP_W'(EP0_PACKET);
    max_pkt[1] = MP_W'(EP0_PACKET);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_requests.push_back(req(A_OUT_RECV, 0, 0, 0, XT_CONTROL, 0, 0, 0));
    pending_requests.push_back(req(A_START, 0, 1, 0, XT_CONTROL, 0, 0, 0));
    pending_requests.push_back(req(A_IN_SENT, 0, 1, 0, XT_CONTROL, 0, 0, 0));
    pending_requests.push_back(req(A_OPEN, 1, 1, 512, XT_CONTROL, 3, 0, 0));
    pending_requests.push_back(req(A_OPEN, 1, 0, 512, XT_ISO, 3, 0, 0));
    pending_requests.push_back(req(A_OPEN, 7, 1, 1023, XT_BULK, 7, 0, 0));
    pending_requests.push_back(req(A_START, 7, 1, 0, XT_BULK, 0, 65535, 0));
    pending_requests.push_back(req(A_IN_SENT, 7, 1, 0, XT_BULK, 0, 0, 0));
    pending_requests.push_back(req(A_OPEN, 7, 0, 1023, XT_INTERRUPT, 5, 0, 0));
    pending_requests.push_back(req(A_START, 7, 0, 0, XT_BULK, 0, 2046, 0));
    pending_requests.push_back(req(A_OUT_RECV, 7, 0, 0, XT_BULK, 0, 0, 1023));
    pending_requests.push_back(req(A_OUT_RECV, 7, 0, 0, XT_BULK, 0, 0, 1023));
    pending_requests.push_back(req(A_OPEN, 3, 0, 0, XT_BULK, 2, 0, 0));
    pending_requests.push_back(req(A_START, 3, 0, 0, XT_BULK, 0, 100, 0));
    pending_requests.push_back(req(A_OUT_RECV, 3, 0, 0, XT_BULK, 0, 0, 0));
    pending_requests.push_back(req(A_OUT_RECV, 3, 0, 0, XT_BULK, 0, 0, 1023));
    pending_requests.push_back(req(A_START, 0, 0, 0, XT_BULK, 0, 65535, 0));
    pending_requests.push_back(req(A_OUT_RECV, 0, 0, 0, XT_BULK, 0, 0, 64));
    pending_requests.push_back(req(A_OUT_RECV, 0, 0, 0, XT_BULK, 0, 0, 10));
    pending_requests.push_back(req(A_START, 2, 1, 0, XT_BULK, 0, 5, 0));
    pending_requests.push_back(req(A_IN_SENT, 2, 1, 0, XT_BULK, 0, 0, 0));
    pending_requests.push_back(req(A_OPEN, 5, 1, 8, XT_INTERRUPT, 1, 0, 0));
    pending_requests.push_back(req(A_START, 5, 1, 0, XT_BULK, 0, 12, 0));
    pending_requests.push_back(req(A_IN_SENT, 5, 0, 0, XT_BULK, 0, 0, 0));
    pending_requests.push_back(req(A_IN_SENT, 5, 1, 0, XT_BULK, 0, 0, 0));

    // The sender holds off here until every queued request has been sent and every outstanding result has come back.
    wait_drained();
    @(negedge clk);
    fill_random(275, 1'b1);
    wait_drained();
    @(negedge clk);
    fill_random(550, 1'b0);

    while (pending_requests.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("usb_endpoint_transfer_segmenter regression: pass");
    end else begin
      $display("usb_endpoint_transfer_segmenter regression: fail");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, expected_outcomes.size());
    $display("usb_endpoint_transfer_segmenter regression: fail");
    $finish;
  end

endmodule
